FILE: hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the checked base64 decoder: character
// classes carried by the queue, decoder phases and done status codes.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int CharW  = 8;
	localparam int ValW   = 6;
	localparam int CountW = 16;
	localparam int StatW  = 2;
	localparam int AccW   = 12;

	// Class of one input beat, decided by the front part
	typedef enum logic [2:0] {
		KIND_SKIP,
		KIND_LETTER,
		KIND_PAD,
		KIND_BAD,
		KIND_END
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [ValW-1:0] value;
	} class_t;

	// Queue fill flags seen by the front and back parts and the top level
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Decoder phase between rearms
	typedef enum logic [1:0] {
		PH_RUN,
		PH_PAD,
		PH_BAD,
		PH_OVF
	} phase_t;

	localparam logic [StatW-1:0] STAT_OK  = 2'd0;
	localparam logic [StatW-1:0] STAT_BAD = 2'd1;
	localparam logic [StatW-1:0] STAT_OVF = 2'd2;

	localparam logic [CountW-1:0] CAP_RESET = 16'd256;

endpackage

FILE: hw/rtl/base64_decoder_checked_unit.sv
// ----------------------------------------------------------------------------
// base64_decoder_checked_unit
// Streaming base64 decoder with malformed and capacity checks.
//
//   channel   dir  beat contents
//   s_*       in   tdata[7:0] ch, tlast end_of_text
//   m_*       out  tdata[7:0] data_byte, [9:8] status, [25:10] byte_count,
//                  tuser byte_valid, tlast done_res
//   cfg_*     in   cfg_wdata out_capacity, written when cfg_we is high
//
// One beat per cycle in and out unless the output stalls. A taken beat goes to
// the queue, then to the output register when it heads the queue and that
// register is free or draining. The back part's single state update per cycle
// sets the rate. Reset clears the queue and decoder state, sets out_capacity to
// 256. An output stall fills the queue; s_tready drops only when it is full.
// ----------------------------------------------------------------------------
module base64_decoder_checked_unit
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] data_byte, [9:8] status, [25:10] byte_count
	output logic        m_tuser,   // byte_valid
	output logic        m_tlast,   // done_res
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata  // out_capacity
);

	logic [CountW-1:0] out_capacity_q;
	queue_stat_t       q_stat;
	logic              push;
	logic              pop;
	class_t            push_item;
	class_t            head_item;
	logic [7:0]        data_byte;
	logic [StatW-1:0]  status;
	logic [CountW-1:0] byte_count;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			out_capacity_q <= cfg_wdata;
		end
	end

	b64d_front u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.ch          (s_tdata),
		.end_of_text (s_tlast),
		.q_stat      (q_stat),
		.push        (push),
		.push_item   (push_item)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.out_capacity (out_capacity_q),
		.q_stat       (q_stat),
		.head_item    (head_item),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.byte_valid   (m_tuser),
		.data_byte    (data_byte),
		.done_res     (m_tlast),
		.status       (status),
		.byte_count   (byte_count)
	);

	// Pack the output beat
	assign m_tdata = {6'd0, byte_count, status, data_byte};

	// Input stalls only when the queue is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_stat.full)
		else $error("s_tready low while queue has room");

	// A beat never carries both a byte and the done report
	a_byte_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser && m_tlast))
		else $error("byte and done on the same beat");

	// Status and count stay zero outside the done beat
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (status == STAT_OK && byte_count == '0))
		else $error("status or count set on a character beat");

	// No pop from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule

FILE: hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts input beats and classifies each character into skip, letter
// (with its six-bit value), pad, malformed or end, then pushes the class.
// ----------------------------------------------------------------------------
module b64d_front
	import b64d_pkg::*;
(
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [CharW-1:0] ch,
	input  logic             end_of_text,
	input  queue_stat_t      q_stat,
	output logic             push,
	output class_t           push_item
);

	// Take a beat whenever the queue has room
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	// Map the character to its class and letter value
	always_comb begin
		push_item.kind  = KIND_BAD;
		push_item.value = '0;
		if (end_of_text) begin
			push_item.kind = KIND_END;
		end else begin
			case (ch) inside
				["A":"Z"]: begin
					push_item.kind  = KIND_LETTER;
					push_item.value = ValW'(ch - 8'h41);
				end
				["a":"z"]: begin
					push_item.kind  = KIND_LETTER;
					push_item.value = ValW'(ch - 8'h61 + 8'd26);
				end
				["0":"9"]: begin
					push_item.kind  = KIND_LETTER;
					push_item.value = ValW'(ch - 8'h30 + 8'd52);
				end
				8'h2B: begin
					push_item.kind  = KIND_LETTER;
					push_item.value = 6'd62;
				end
				8'h2F: begin
					push_item.kind  = KIND_LETTER;
					push_item.value = 6'd63;
				end
				8'h3D: begin
					push_item.kind = KIND_PAD;
				end
				8'h20, 8'h09, 8'h0D, 8'h0A: begin
					push_item.kind = KIND_SKIP;
				end
				default: begin
					push_item.kind = KIND_BAD;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short first-in first-out queue of classified beats between the front
// and back parts.
// ----------------------------------------------------------------------------
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = 2
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  class_t      push_item,
	input  logic        pop,
	output class_t      head_item,
	output queue_stat_t q_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] Full    = CW'(DEPTH);

	class_t          entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_item    = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == Full);
	assign q_stat.empty = (count_q == '0);

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Executes classified beats: accumulates letter bits, emits bytes, tracks
// padding, malformed and overflow phases, and reports on the end beat.
// ----------------------------------------------------------------------------
module b64d_back
	import b64d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CountW-1:0] out_capacity,
	input  queue_stat_t       q_stat,
	input  class_t            head_item,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              byte_valid,
	output logic [7:0]        data_byte,
	output logic              done_res,
	output logic [StatW-1:0]  status,
	output logic [CountW-1:0] byte_count
);

	logic [AccW-1:0]   acc_q;
	logic [2:0]        held_q;
	logic [CountW-1:0] bytes_q;
	phase_t            phase_q;
	logic              out_valid_q;

	logic [AccW-1:0]   acc_new;
	logic [3:0]        held_sum;
	logic [2:0]        held_rem;
	logic [AccW-1:0]   acc_shift;

	logic [AccW-1:0]   acc_d;
	logic [2:0]        held_d;
	logic [CountW-1:0] bytes_d;
	phase_t            phase_d;
	logic              bv_d;
	logic [7:0]        byte_d;
	logic              done_d;
	logic [StatW-1:0]  stat_d;
	logic [CountW-1:0] count_d;

	// Pop when a beat waits and the output register is free or draining
	assign pop      = !q_stat.empty && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	assign acc_new   = {acc_q[AccW-ValW-1:0], head_item.value};
	assign held_sum  = {1'b0, held_q} + 4'd6;
	assign held_rem  = held_sum[2:0];
	assign acc_shift = acc_new >> held_rem;

	// Next decoder state and result for the head beat
	always_comb begin
		acc_d   = acc_q;
		held_d  = held_q;
		bytes_d = bytes_q;
		phase_d = phase_q;
		bv_d    = 1'b0;
		byte_d  = '0;
		done_d  = 1'b0;
		stat_d  = STAT_OK;
		count_d = '0;
		if (head_item.kind == KIND_END) begin
			done_d = 1'b1;
			unique case (phase_q)
				PH_BAD:  stat_d = STAT_BAD;
				PH_OVF:  stat_d = STAT_OVF;
				default: stat_d = STAT_OK;
			endcase
			count_d = (phase_q == PH_BAD || phase_q == PH_OVF) ? '0 : bytes_q;
			acc_d   = '0;
			held_d  = '0;
			bytes_d = '0;
			phase_d = PH_RUN;
		end else if (phase_q == PH_RUN) begin
			unique case (head_item.kind)
				KIND_PAD: phase_d = PH_PAD;
				KIND_BAD: phase_d = PH_BAD;
				KIND_LETTER: begin
					acc_d = acc_new;
					if (held_sum[3]) begin
						held_d = held_rem;
						if (bytes_q >= out_capacity) begin
							phase_d = PH_OVF;
						end else begin
							bv_d    = 1'b1;
							byte_d  = acc_shift[7:0];
							bytes_d = bytes_q + 1'b1;
						end
					end else begin
						held_d = held_sum[2:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			held_q  <= '0;
			bytes_q <= '0;
			phase_q <= PH_RUN;
		end else if (pop) begin
			acc_q   <= acc_d;
			held_q  <= held_d;
			bytes_q <= bytes_d;
			phase_q <= phase_d;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (pop) begin
			byte_valid <= bv_d;
			data_byte  <= byte_d;
			done_res   <= done_d;
			status     <= stat_d;
			byte_count <= count_d;
		end
	end

endmodule
